// ===== hdl/wls_pkg.sv =====
`default_nettype none
package wls_pkg;
  localparam int NUM_AXES = 3;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_LOAD    = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_SEG_COUNT = 2'd1,
    CFG_REPEAT    = 2'd2,
    CFG_NONE      = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DECIDE,
    ST_DIV,
    ST_ADD,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== hdl/waypoint_lerp_sequencer_top.sv =====
`default_nettype none
// a tick walks ST_READ, ST_DECIDE and ST_OUT, and when it interpolates also ST_DIV and ST_ADD,
// where each axis lane runs its serial divide over PW = POS_WIDTH+1+TIME_WIDTH (57 at default) bits
// s_tready is high only in ST_IDLE, so no new item is taken until the last tick is through;
// a result stalled on m_tready keeps the tick in ST_OUT and so holds the next
// loads, restarts, disabled ticks and unused kinds are taken in ST_IDLE and give no result
// rst clears playback state and configuration; the segment table is undefined until loaded
module waypoint_lerp_sequencer_top #(
  parameter int MAX_SEGMENTS = 16,
  parameter int POS_WIDTH    = 32,
  parameter int TIME_WIDTH   = 24
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [4:0]   cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // kind, seg_index, start_x/y/z, end_x/y/z, seg_duration, seg_repeats, time_step
  input  wire logic [8*((6+6*POS_WIDTH+TIME_WIDTH+24+7)/8)-1:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // pos_x, pos_y, pos_z, segment, done_res
  output logic [8*((3*POS_WIDTH+6+7)/8)-1:0] m_tdata
);
  import wls_pkg::*;

  localparam int IW  = $clog2(MAX_SEGMENTS) > 0 ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SW  = $clog2(MAX_SEGMENTS + 1);
  localparam int PW  = POS_WIDTH + 1 + TIME_WIDTH;
  localparam int CW  = $clog2(PW + 1);
  localparam int EW  = 6 * POS_WIDTH + TIME_WIDTH + 8;
  localparam int OB  = 3 * POS_WIDTH;
  localparam int PD  = 6;
  localparam int TB  = PD + 6 * POS_WIDTH;

  // input field slices
  kind_t                 in_kind;
  logic [3:0]            in_idx;
  logic [TIME_WIDTH-1:0] in_step;
  logic [EW-1:0]         in_entry;
  assign in_kind  = kind_t'(s_tdata[1:0]);
  assign in_idx   = s_tdata[5:2];
  assign in_entry = {s_tdata[TB+TIME_WIDTH +: 8], s_tdata[TB +: TIME_WIDTH],
                     s_tdata[TB-1:PD]};
  assign in_step  = TIME_WIDTH'(s_tdata[TB+TIME_WIDTH+8 +: 16]);

  // configuration
  logic       enable, repeat_all;
  logic [4:0] seg_count;
  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b1;
      seg_count  <= 5'd1;
      repeat_all <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:    enable     <= cfg_data[0];
        CFG_SEG_COUNT: seg_count  <= cfg_data;
        CFG_REPEAT:    repeat_all <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] count;
  always_comb begin
    if (seg_count == 5'd0) count = SW'(1);
    else if (32'(seg_count) > MAX_SEGMENTS) count = SW'(MAX_SEGMENTS);
    else count = SW'(seg_count);
  end

  // segment table: one entry holds start, end, duration, repeats
  logic          tbl_we;
  logic [IW-1:0] tbl_raddr;
  logic [EW-1:0] tbl_rdata;
  assign tbl_we = s_tvalid && s_tready && in_kind == KIND_LOAD
                  && 32'(in_idx) < MAX_SEGMENTS;
  wls_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_table (
    .clk(clk), .we(tbl_we), .waddr(IW'(in_idx)), .wdata(in_entry),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  logic [POS_WIDTH-1:0]  e_start [3];
  logic [POS_WIDTH-1:0]  e_end [3];
  logic [TIME_WIDTH-1:0] e_dur;
  logic [7:0]            e_rep;
  for (genvar a = 0; a < 3; a++) begin : g_fields
    assign e_start[a] = tbl_rdata[a*POS_WIDTH +: POS_WIDTH];
    assign e_end[a]   = tbl_rdata[(a+3)*POS_WIDTH +: POS_WIDTH];
  end
  assign e_dur = tbl_rdata[6*POS_WIDTH +: TIME_WIDTH];
  assign e_rep = tbl_rdata[6*POS_WIDTH+TIME_WIDTH +: 8];

  // playback state
  state_t                state, state_next;
  logic [TIME_WIDTH-1:0] elapsed, step_r;
  logic [SW-1:0]         cur_seg;
  logic [7:0]            passes;
  logic                  reverse, finished;
  logic [POS_WIDTH-1:0]  last_pos [3];
  logic [CW-1:0]         div_cnt;
  logic                  lane_load, lane_step;
  logic [POS_WIDTH-1:0]  lane_pos [3];
  logic                  out_free;

  assign tbl_raddr = IW'(cur_seg);
  assign s_tready  = state == ST_IDLE;
  // the output register is free once its transaction is taken
  assign out_free  = !m_tvalid || m_tready;

  logic [TIME_WIDTH:0] el_sum;
  assign el_sum = {1'b0, elapsed} + {1'b0, step_r};
  logic [TIME_WIDTH-1:0] el_sat;
  assign el_sat = el_sum[TIME_WIDTH] ? '1 : el_sum[TIME_WIDTH-1:0];

  // axis lanes share elapsed and duration, differ in their endpoints
  for (genvar a = 0; a < 3; a++) begin : g_lane
    wls_lane #(.POS_WIDTH(POS_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_lane (
      .clk(clk), .load(lane_load), .step(lane_step),
      .from_pt(reverse ? e_end[a] : e_start[a]),
      .to_pt(reverse ? e_start[a] : e_end[a]),
      .elapsed(el_sat), .dur(e_dur), .pos(lane_pos[a])
    );
  end

  always_comb begin
    state_next = state;
    lane_load  = 1'b0;
    lane_step  = 1'b0;
    case (state)
      ST_IDLE:   if (s_tvalid && s_tready && in_kind == KIND_TICK && enable)
                   state_next = ST_READ;
      ST_READ:   state_next = ST_DECIDE;
      ST_DECIDE: begin
        state_next = ST_OUT;
        if (!finished && cur_seg < count && e_dur != '0 && el_sat < e_dur) begin
          state_next = ST_DIV;
          lane_load  = 1'b1;
        end
      end
      ST_DIV: begin
        lane_step = 1'b1;
        if (div_cnt == CW'(PW - 1)) state_next = ST_ADD;
      end
      ST_ADD:    state_next = ST_OUT;
      // wait here while the previous result is still unaccepted
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      elapsed  <= '0;
      cur_seg  <= '0;
      passes   <= '0;
      reverse  <= 1'b0;
      finished <= 1'b0;
      m_tvalid <= 1'b0;
      div_cnt  <= '0;
      for (int a = 0; a < 3; a++) last_pos[a] <= '0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          step_r <= in_step;
          if (s_tvalid && s_tready && in_kind == KIND_RESTART) begin
            elapsed  <= '0;
            cur_seg  <= '0;
            passes   <= '0;
            reverse  <= 1'b0;
            finished <= 1'b0;
          end else if (s_tvalid && s_tready && in_kind == KIND_TICK && enable
                       && !finished && cur_seg >= count) begin
            // end-of-path rule before the table read
            if (repeat_all) begin
              cur_seg <= '0;
              passes  <= '0;
              reverse <= 1'b0;
              elapsed <= '0;
            end else begin
              finished <= 1'b1;
            end
          end
        end
        ST_DECIDE: begin
          div_cnt <= '0;
          if (!finished) begin
            if (e_dur == '0) begin
              for (int a = 0; a < 3; a++) last_pos[a] <= e_end[a];
              elapsed <= '0;
              passes  <= '0;
              cur_seg <= cur_seg + SW'(1);
            end else if (el_sat < e_dur) begin
              elapsed <= el_sat;
            end else begin
              elapsed <= '0;
              if (reverse) begin
                for (int a = 0; a < 3; a++) last_pos[a] <= e_start[a];
                reverse <= 1'b0;
              end else begin
                for (int a = 0; a < 3; a++) last_pos[a] <= e_end[a];
                if (passes >= e_rep) begin
                  cur_seg <= cur_seg + SW'(1);
                  passes  <= '0;
                end else begin
                  reverse <= 1'b1;
                  passes  <= passes + 8'd1;
                end
              end
            end
          end
        end
        ST_DIV: div_cnt <= div_cnt + CW'(1);
        ST_ADD: for (int a = 0; a < 3; a++) last_pos[a] <= lane_pos[a];
        ST_OUT: begin
          // end-of-path rule after an advance
          if (out_free && !finished && cur_seg >= count) begin
            if (repeat_all) begin
              cur_seg <= '0;
              passes  <= '0;
              reverse <= 1'b0;
              elapsed <= '0;
            end else begin
              finished <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result register; the end-of-path update lands in the same edge, so look ahead
  logic [SW-1:0]        seg_o;
  logic                 fin_o;
  logic [POS_WIDTH-1:0] pos_o [3];
  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      for (int a = 0; a < 3; a++) pos_o[a] <= last_pos[a];
      seg_o <= cur_seg;
      fin_o <= finished;
      if (!finished && cur_seg >= count) begin
        if (repeat_all) seg_o <= '0;
        else fin_o <= 1'b1;
      end
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[0 +: POS_WIDTH]           = pos_o[0];
    m_tdata[POS_WIDTH +: POS_WIDTH]   = pos_o[1];
    m_tdata[2*POS_WIDTH +: POS_WIDTH] = pos_o[2];
    m_tdata[OB +: 5]                  = 5'(seg_o);
    m_tdata[OB+5]                     = fin_o;
  end
endmodule
`default_nettype wire

// ===== hdl/wls_ram.sv =====
`default_nettype none
module wls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/wls_lane.sv =====
`default_nettype none
// one axis: a + sign * floor(|b-a| * e / d), bit-serial restoring divide
module wls_lane #(
  parameter int POS_WIDTH  = 32,
  parameter int TIME_WIDTH = 24
) (
  input  wire logic                  clk,
  input  wire logic                  load,
  input  wire logic                  step,
  input  wire logic [POS_WIDTH-1:0]  from_pt,
  input  wire logic [POS_WIDTH-1:0]  to_pt,
  input  wire logic [TIME_WIDTH-1:0] elapsed,
  input  wire logic [TIME_WIDTH-1:0] dur,
  output logic      [POS_WIDTH-1:0]  pos
);
  localparam int MW = POS_WIDTH + 1;
  localparam int PW = MW + TIME_WIDTH;

  logic [POS_WIDTH-1:0]  base;
  logic                  neg;
  logic [PW-1:0]         prod;
  logic [TIME_WIDTH:0]   rem;
  logic [MW:0]           diff;
  logic [MW-1:0]         mag;
  logic [TIME_WIDTH+1:0] trial;

  assign diff  = {{2{to_pt[POS_WIDTH-1]}}, to_pt} - {{2{from_pt[POS_WIDTH-1]}}, from_pt};
  assign mag   = diff[MW] ? MW'(-diff) : diff[MW-1:0];
  assign trial = {rem, prod[PW-1]} - {2'b0, dur};

  // product mag*e, formed by shift-add in the same loop is too slow; one multiply here
  always_ff @(posedge clk) begin
    if (load) begin
      base <= from_pt;
      neg  <= diff[MW];
      prod <= PW'(mag) * PW'(elapsed);
      rem  <= '0;
    end else if (step) begin
      if (!trial[TIME_WIDTH+1]) begin
        rem  <= trial[TIME_WIDTH:0];
        prod <= {prod[PW-2:0], 1'b1};
      end else begin
        rem  <= {rem[TIME_WIDTH-1:0], prod[PW-1]};
        prod <= {prod[PW-2:0], 1'b0};
      end
    end
  end

  assign pos = neg ? base - prod[POS_WIDTH-1:0] : base + prod[POS_WIDTH-1:0];
endmodule
`default_nettype wire

// ===== tb/waypoint_lerp_sequencer_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module waypoint_lerp_sequencer_checker
  import wls_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [4:0]   cfg_data,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [247:0] s_tdata,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [103:0] m_tdata,
  output int                errors,
  output int                pending
);
  typedef struct {
    logic [31:0] pos [3];
    logic [4:0]  seg;
    logic        done;
  } pose_t;

  logic [31:0] path_from [16][3];
  logic [31:0] path_to   [16][3];
  logic [23:0] path_dur  [16];
  logic [7:0]  path_rep  [16];
  logic [23:0] elapsed;
  logic [4:0]  cur_seg;
  logic [7:0]  passes;
  logic        backward;
  logic        finished;
  logic [31:0] held_pos [3];
  logic        en_reg;
  logic [4:0]  count_reg;
  logic        loop_reg;
  pose_t       pose_q [$];

  assign pending = pose_q.size();

  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b,
                                        logic [23:0] e, logic [23:0] d);
    longint sa, sb, diff;
    longint unsigned mag, q;
    sa = longint'(signed'(a));
    sb = longint'(signed'(b));
    diff = sb - sa;
    mag = (diff < 0) ? longint'(-diff) : longint'(diff);
    q = (mag * e) / d;
    return (diff < 0) ? 32'(sa - longint'(q)) : 32'(sa + longint'(q));
  endfunction

  function automatic int path_len();
    if (count_reg == 0) return 1;
    if (count_reg > 16) return 16;
    return count_reg;
  endfunction

  function automatic void wrap_or_finish(int n);
    if (cur_seg >= n) begin
      if (loop_reg) begin
        cur_seg = 0;
        passes = 0;
        backward = 0;
        elapsed = 0;
      end else begin
        finished = 1;
      end
    end
  endfunction

  function automatic void advance_playhead(logic [15:0] step);
    int n;
    int s;
    logic [24:0] sum;
    n = path_len();
    if (finished) return;
    wrap_or_finish(n);
    if (finished) return;
    s = cur_seg;
    if (path_dur[s] == 0) begin
      held_pos = path_to[s];
      elapsed = 0;
      cur_seg++;
      passes = 0;
      wrap_or_finish(n);
      return;
    end
    // elapsed saturates rather than wrapping
    sum = elapsed + step;
    elapsed = sum[24] ? 24'hFFFFFF : sum[23:0];
    if (elapsed < path_dur[s]) begin
      for (int k = 0; k < 3; k++)
        held_pos[k] = backward ? blend(path_to[s][k], path_from[s][k], elapsed, path_dur[s])
                               : blend(path_from[s][k], path_to[s][k], elapsed, path_dur[s]);
      return;
    end
    elapsed = 0;
    if (backward) begin
      held_pos = path_from[s];
      backward = 0;
    end else begin
      held_pos = path_to[s];
      if (passes >= path_rep[s]) begin
        cur_seg++;
        passes = 0;
      end else begin
        backward = 1;
        passes++;
      end
    end
    wrap_or_finish(n);
  endfunction

  always @(posedge clk) begin
    pose_t want;
    pose_t got;
    if (rst) begin
      elapsed = 0;
      cur_seg = 0;
      passes = 0;
      backward = 0;
      finished = 0;
      held_pos = '{default: 32'd0};
      en_reg <= 1;
      count_reg <= 1;
      loop_reg <= 0;
      pose_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ENABLE:    en_reg <= cfg_data[0];
          CFG_SEG_COUNT: count_reg <= cfg_data;
          CFG_REPEAT:    loop_reg <= cfg_data[0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        for (int k = 0; k < 3; k++) got.pos[k] = m_tdata[32*k +: 32];
        got.seg = m_tdata[100:96];
        got.done = m_tdata[101];
        if (pose_q.size() == 0) begin
          $error("unexpected result transaction");
          errors = errors + 1;
        end else begin
          want = pose_q.pop_front();
          for (int k = 0; k < 3; k++)
            if (got.pos[k] !== want.pos[k]) begin
              $error("pos[%0d] expected %h actual %h", k, want.pos[k], got.pos[k]);
              errors = errors + 1;
            end
          if (got.seg !== want.seg) begin
            $error("segment expected %0d actual %0d", want.seg, got.seg);
            errors = errors + 1;
          end
          if (got.done !== want.done) begin
            $error("done_res expected %0d actual %0d", want.done, got.done);
            errors = errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        case (kind_t'(s_tdata[1:0]))
          KIND_LOAD: begin
            for (int k = 0; k < 3; k++) begin
              path_from[s_tdata[5:2]][k] = s_tdata[6 + 32*k +: 32];
              path_to[s_tdata[5:2]][k] = s_tdata[102 + 32*k +: 32];
            end
            path_dur[s_tdata[5:2]] = s_tdata[221:198];
            path_rep[s_tdata[5:2]] = s_tdata[229:222];
          end
          KIND_RESTART: begin
            elapsed = 0;
            cur_seg = 0;
            passes = 0;
            backward = 0;
            finished = 0;
          end
          KIND_TICK: if (en_reg) begin
            advance_playhead(s_tdata[245:230]);
            want.pos = held_pos;
            want.seg = cur_seg;
            want.done = finished;
            pose_q = {pose_q, want};
          end
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/waypoint_lerp_sequencer_top_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module waypoint_lerp_sequencer_top_test;
  import wls_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [3:0]  idx;
    logic [31:0] from_pt [3];
    logic [31:0] to_pt [3];
    logic [23:0] dur;
    logic [7:0]  rep;
    logic [15:0] step;
  } cmd_t;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [4:0]   cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  // kind, seg_index, start_x/y/z, end_x/y/z, seg_duration, seg_repeats, time_step
  logic [247:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // pos_x, pos_y, pos_z, segment, done_res
  logic [103:0] m_tdata;
  int           errors;
  int           pending;
  logic         calm;        // no idling on either side while set
  logic         hold_go;     // asks the receiver for one long hold-off
  int           hold_left;
  int           quiet_cycles;

  waypoint_lerp_sequencer_top DUT (.*);

  waypoint_lerp_sequencer_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // receiver: random back-pressure, plus the long hold-off that fills the block
  initial begin
    bit spent;
    spent = 0;
    m_tready = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_go && !spent) begin
        hold_left = 300;
        spent = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 36);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= 20000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic [31:0] coord();
    case ($urandom_range(9))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'h0;
      3: return $urandom_range(255) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t load_cmd(logic [3:0] idx);
    cmd_t c;
    c.kind = KIND_LOAD;
    c.idx = idx;
    for (int k = 0; k < 3; k++) begin
      c.from_pt[k] = coord();
      c.to_pt[k] = coord();
    end
    case ($urandom_range(49))
      0:       c.dur = 24'hFFFFFF;
      1:       c.dur = 24'($urandom_range(24'hFFFFFF));
      2, 3, 4, 5, 6: c.dur = 0;
      default: c.dur = 24'($urandom_range(1, 200));
    endcase
    c.rep = ($urandom_range(29) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
    c.step = 16'($urandom);
    return c;
  endfunction

  function automatic cmd_t tick_cmd(logic [15:0] step);
    cmd_t c;
    c = load_cmd(4'($urandom));
    c.kind = KIND_TICK;
    c.step = step;
    return c;
  endfunction

  function automatic logic [15:0] rand_step();
    case ($urandom_range(19))
      0:       return 16'hFFFF;
      1:       return 16'($urandom);
      2:       return 16'd0;
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic cmd_t mixed_cmd();
    int r;
    cmd_t c;
    r = $urandom_range(99);
    if (r < 76) return tick_cmd(rand_step());
    if (r < 92) return load_cmd(4'($urandom));
    c = tick_cmd(rand_step());
    c.kind = (r < 97) ? KIND_RESTART : KIND_UNUSED;
    return c;
  endfunction

  // offer one transaction; s_tvalid stays high on return so back-to-back items need no drop
  task automatic send(cmd_t c);
    logic [247:0] packed_bits;
    if (!calm && $urandom_range(99) < 36) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    packed_bits = '0;
    packed_bits[1:0] = c.kind;
    packed_bits[5:2] = c.idx;
    for (int k = 0; k < 3; k++) begin
      packed_bits[6 + 32*k +: 32] = c.from_pt[k];
      packed_bits[102 + 32*k +: 32] = c.to_pt[k];
    end
    packed_bits[221:198] = c.dur;
    packed_bits[229:222] = c.rep;
    packed_bits[245:230] = c.step;
    s_tvalid <= 1;
    s_tdata <= packed_bits;
    do @(posedge clk); while (!s_tready);
  endtask

  // registers change only once the block has drained, a dividing tick included
  task automatic write_reg(cfg_idx_t idx, logic [4:0] val);
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    cmd_t c;
    logic [4:0] counts [6] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd3, 5'd8};
    rst = 1;
    cfg_we = 0;
    cfg_index = CFG_ENABLE;
    cfg_data = 0;
    s_tvalid = 0;
    s_tdata = '0;
    calm = 0;
    hold_go = 0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: fill the whole table first, so no tick ever reads an unloaded entry
    for (int i = 0; i < 16; i++) begin
      c = load_cmd(4'(i));
      if (i == 0) begin
        c.from_pt = '{32'h80000000, 32'h7FFFFFFF, 32'h0};
        c.to_pt = '{32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF};
        c.dur = 24'd5;
        c.rep = 8'd1;
      end
      if (i == 1) c.dur = 0;
      send(c);
    end
    // forward, reverse, forward again, then finish and a tick while finished
    send(tick_cmd(16'd0));
    send(tick_cmd(16'd1));
    send(tick_cmd(16'd3));
    send(tick_cmd(16'hFFFF));
    send(tick_cmd(16'd2));
    send(tick_cmd(16'hFFFF));
    send(tick_cmd(16'd5));
    send(tick_cmd(16'd7));
    c = mixed_cmd();
    c.kind = KIND_UNUSED;
    send(c);
    c.kind = KIND_RESTART;
    send(c);
    write_reg(CFG_ENABLE, 5'd0);
    send(tick_cmd(16'd1));
    write_reg(CFG_ENABLE, 5'd1);

    // elapsed saturation: longest duration walked with the largest steps
    c = load_cmd(4'd0);
    c.dur = 24'hFFFFFF;
    c.rep = 0;
    send(c);
    c.kind = KIND_RESTART;
    send(c);
    for (int i = 0; i < 258; i++) send(tick_cmd(16'hFFFF));
    c = load_cmd(4'd0);
    c.dur = 24'd20;
    send(c);

    // random phases over several register settings
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CFG_SEG_COUNT, (ph < 6) ? counts[ph] : 5'($urandom_range(31)));
      write_reg(CFG_REPEAT, 5'(ph % 3 != 0));
      write_reg(CFG_ENABLE, 5'($urandom_range(5) != 0));
      calm = (ph == 2);
      if (ph == 5) hold_go = 1;
      for (int i = 0; i < 125; i++) begin
        if (ph == 5 && i == 10) hold_go = 0;
        send(mixed_cmd());
      end
    end
    calm = 0;
    write_reg(CFG_ENABLE, 5'd1);
    s_tvalid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
